// ----- hdl/svcn_pkg.sv -----
// shared types and constants for the sweep vertex collision nudger
package svcn_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_W          = 32;
    localparam int TRIG_W           = 16;
    localparam int CFG_W            = 16;
    // full-scale negative axis with both coordinates at the negative limit
    // projects to +2^33, one bit beyond a 34-bit signed field
    localparam int PROJ_W           = 35;
    localparam int OUT_IDX_W        = 6;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int FRAC_SHIFT       = 14;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_AXIS_COS = 2'd0,
        CFG_AXIS_SIN = 2'd1,
        CFG_EPSILON  = 2'd2,
        CFG_STEP     = 2'd3
    } cfg_index_t;

    // one classified vertex word passed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PROJ_W-1:0]  p;
        logic               last;
    } vertex_entry_t;

endpackage

// ----- hdl/sweep_vertex_collision_nudger.sv -----
// Sweep vertex collision nudger: loads a vertex list, nudges colliding
// vertices along the sweep axis and returns them in load order.
//
// Input channel (in_valid / in_stall) takes one vertex word per item; the
// word flagged last_vertex closes the list. Up to MAX_VERTICES words are
// kept, later ones are dropped and flag overflow on every output word.
// Each input word passes the projection front end, which takes a new word
// only once the last has left it, then the sorted insertion, which reads
// and compares each stored entry it walks past through the sorted-list
// memory port. After the last word, the grouping pass visits each vertex,
// then output words leave in load order, last_out on the final one.
// Output words sit in a register; while out_stall is high a valid word
// holds and the emit sequence waits. The user must write the
// configuration port only between runs; the block itself does not
// enforce it. Reset clears the vertex count, overflow and all valid
// flags; the registers return to cos 1.0, sin 0, epsilon 7, step 7.
module sweep_vertex_collision_nudger
    import svcn_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_y,
    input  logic                      last_vertex,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [OUT_IDX_W-1:0]      load_index,
    output logic signed [COORD_W-1:0] new_x,
    output logic signed [COORD_W-1:0] new_y,
    output logic                      last_out,
    output logic                      overflow
);

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic [CFG_W-1:0]         eps_reg;
    logic [CFG_W-1:0]         step_reg;
    logic                     push;
    logic                     push_ready;
    vertex_entry_t            push_data;
    logic                     pop;
    logic                     pop_valid;
    vertex_entry_t            pop_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg  <= 16'sd16384;
            sin_reg  <= '0;
            eps_reg  <= 16'd7;
            step_reg <= 16'd7;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_AXIS_COS: cos_reg  <= cfg_data;
                CFG_AXIS_SIN: sin_reg  <= cfg_data;
                CFG_EPSILON:  eps_reg  <= cfg_data;
                CFG_STEP:     step_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // projection front end
    svcn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .last_vertex (last_vertex),
        .axis_cos    (cos_reg),
        .axis_sin    (sin_reg),
        .push        (push),
        .push_data   (push_data),
        .push_ready  (push_ready)
    );

    // decoupling queue
    svcn_queue #(
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid)
    );

    // sort, group and emit back end
    svcn_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (pop_valid),
        .q_data            (pop_data),
        .q_pop             (pop),
        .axis_cos          (cos_reg),
        .axis_sin          (sin_reg),
        .gap_limit         (eps_reg),
        .nudge_step        (step_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .load_index        (load_index),
        .new_x             (new_x),
        .new_y             (new_y),
        .last_out          (last_out),
        .overflow          (overflow)
    );

endmodule

// ----- hdl/svcn_front.sv -----
// front end: accepts vertex words and computes the axis projection
module svcn_front
    import svcn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [COORD_W-1:0] vertex_x,
    input  logic signed [COORD_W-1:0] vertex_y,
    input  logic                     last_vertex,
    input  logic signed [TRIG_W-1:0] axis_cos,
    input  logic signed [TRIG_W-1:0] axis_sin,
    output logic                     push,
    output vertex_entry_t            push_data,
    input  logic                     push_ready
);

    localparam int PRODUCT_W = COORD_W + TRIG_W;

    logic                        s1_valid_reg;
    logic signed [COORD_W-1:0]   s1_x_reg;
    logic signed [COORD_W-1:0]   s1_y_reg;
    logic                        s1_last_reg;
    logic                        s2_valid_reg;
    logic signed [COORD_W-1:0]   s2_x_reg;
    logic signed [COORD_W-1:0]   s2_y_reg;
    logic                        s2_last_reg;
    logic signed [PRODUCT_W-1:0] s2_px_reg;
    logic signed [PRODUCT_W-1:0] s2_py_reg;
    logic signed [PRODUCT_W:0]   proj_sum;
    logic signed [PRODUCT_W:0]   proj_shift;
    logic                        accept;

    // one word in flight at a time
    assign in_stall = s1_valid_reg | s2_valid_reg | ~push_ready;
    assign accept   = in_valid & ~in_stall;

    // projection sum with floor shift
    assign proj_sum   = (PRODUCT_W+1)'(s2_px_reg) + (PRODUCT_W+1)'(s2_py_reg);
    assign proj_shift = proj_sum >>> FRAC_SHIFT;

    assign push             = s2_valid_reg & push_ready;
    assign push_data.x      = s2_x_reg;
    assign push_data.y      = s2_y_reg;
    assign push_data.p      = proj_shift[PROJ_W-1:0];
    assign push_data.last   = s2_last_reg;

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
                s2_valid_reg <= 1'b1;
            else if (push)
                s2_valid_reg <= 1'b0;
        end
    end

    // input capture and products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= vertex_x;
            s1_y_reg    <= vertex_y;
            s1_last_reg <= last_vertex;
        end
        if (s1_valid_reg)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_last_reg <= s1_last_reg;
            s2_px_reg   <= s1_x_reg * axis_cos;
            s2_py_reg   <= s1_y_reg * axis_sin;
        end
    end

endmodule

// ----- hdl/svcn_queue.sv -----
// short queue between the front and the back end
module svcn_queue
    import svcn_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vertex_entry_t push_data,
    output logic          push_ready,
    input  logic          pop,
    output vertex_entry_t pop_data,
    output logic          pop_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vertex_entry_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hdl/svcn_back.sv -----
// back end: sorted insertion, collision grouping and nudged output
module svcn_back
    import svcn_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  vertex_entry_t            q_data,
    output logic                     q_pop,
    input  logic signed [TRIG_W-1:0] axis_cos,
    input  logic signed [TRIG_W-1:0] axis_sin,
    input  logic [CFG_W-1:0]         gap_limit,
    input  logic [CFG_W-1:0]         nudge_step,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [OUT_IDX_W-1:0]     load_index,
    output logic signed [COORD_W-1:0] new_x,
    output logic signed [COORD_W-1:0] new_y,
    output logic                     last_out,
    output logic                     overflow
);

    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int DW   = IW + CFG_W;
    localparam int PW   = DW + 1 + TRIG_W;
    localparam int SW   = PW + COORD_W + 1;
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sh7FFFFFFF);
    localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_INS_RD  = 10'b00_0000_0010,
        ST_INS_CMP = 10'b00_0000_0100,
        ST_INS_PUT = 10'b00_0000_1000,
        ST_GRP_RD  = 10'b00_0001_0000,
        ST_GRP_CHK = 10'b00_0010_0000,
        ST_EM_RD   = 10'b00_0100_0000,
        ST_EM_M1   = 10'b00_1000_0000,
        ST_EM_M2   = 10'b01_0000_0000,
        ST_EM_OUT  = 10'b10_0000_0000
    } state_t;

    // memories
    logic [COORD_W-1:0] x_mem    [MAX_VERTICES];
    logic [COORD_W-1:0] y_mem    [MAX_VERTICES];
    logic [PROJ_W-1:0]  srt_p_mem[MAX_VERTICES];
    logic [IW-1:0]      srt_i_mem[MAX_VERTICES];
    logic [IW-1:0]      rank_mem [MAX_VERTICES];

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      walk_reg, walk_next;
    vertex_entry_t      cur_reg, cur_next;
    logic signed [PROJ_W-1:0] base_reg, base_next;
    logic [IW-1:0]      rank_reg, rank_next;

    logic [PROJ_W-1:0]  srt_p_q;
    logic [IW-1:0]      srt_i_q;
    logic [COORD_W-1:0] x_q;
    logic [COORD_W-1:0] y_q;
    logic [IW-1:0]      rank_q;
    logic [DW-1:0]      d_reg;
    logic signed [PW-1:0] dx_reg;
    logic signed [PW-1:0] dy_reg;

    logic               out_valid_reg;
    logic [OUT_IDX_W-1:0] idx_out_reg;
    logic [COORD_W-1:0] nx_out_reg;
    logic [COORD_W-1:0] ny_out_reg;
    logic               last_out_reg;
    logic               ovf_out_reg;

    logic               srt_we;
    logic [IW-1:0]      srt_waddr;
    logic [PROJ_W-1:0]  srt_wp;
    logic [IW-1:0]      srt_wi;
    logic [IW-1:0]      srt_raddr;
    logic               xy_we;
    logic               rank_we;
    logic               out_load;
    logic [CW-1:0]      pos_dec;
    logic [CW-1:0]      walk_inc;
    logic signed [PROJ_W:0] gap;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [COORD_W-1:0] sat_x;
    logic signed [COORD_W-1:0] sat_y;

    assign pos_dec  = pos_reg - 1'b1;
    assign walk_inc = walk_reg + 1'b1;
    assign gap      = (PROJ_W+1)'($signed(srt_p_q)) - (PROJ_W+1)'(base_reg);

    // nudged coordinates with saturation
    assign sum_x = SW'($signed(x_q)) + SW'(dx_reg >>> FRAC_SHIFT);
    assign sum_y = SW'($signed(y_q)) + SW'(dy_reg >>> FRAC_SHIFT);
    assign sat_x = (sum_x > SAT_MAX) ? COORD_W'(SAT_MAX) :
                   (sum_x < SAT_MIN) ? COORD_W'(SAT_MIN) : COORD_W'(sum_x);
    assign sat_y = (sum_y > SAT_MAX) ? COORD_W'(SAT_MAX) :
                   (sum_y < SAT_MIN) ? COORD_W'(SAT_MIN) : COORD_W'(sum_y);

    assign out_load = (state_reg == ST_EM_OUT) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        pos_next   = pos_reg;
        walk_next  = walk_reg;
        cur_next   = cur_reg;
        base_next  = base_reg;
        rank_next  = rank_reg;
        q_pop      = 1'b0;
        xy_we      = 1'b0;
        rank_we    = 1'b0;
        srt_we     = 1'b0;
        srt_waddr  = pos_reg[IW-1:0];
        srt_wp     = srt_p_q;
        srt_wi     = srt_i_q;
        srt_raddr  = walk_reg[IW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_data;
                    pos_next = count_reg;
                    walk_next = '0;
                    if (count_reg != CW'(MAX_VERTICES))
                    begin
                        xy_we = 1'b1;
                        state_next = (count_reg == '0) ? ST_INS_PUT : ST_INS_RD;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                        if (q_data.last)
                            state_next = ST_GRP_RD;
                    end
                end
            end
            ST_INS_RD:
            begin
                srt_raddr  = pos_dec[IW-1:0];
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                if ($signed(srt_p_q) > $signed(cur_reg.p))
                begin
                    srt_we   = 1'b1;
                    pos_next = pos_dec;
                    state_next = (pos_dec == '0) ? ST_INS_PUT : ST_INS_RD;
                end
                else
                    state_next = ST_INS_PUT;
            end
            ST_INS_PUT:
            begin
                srt_we     = 1'b1;
                srt_wp     = cur_reg.p;
                srt_wi     = count_reg[IW-1:0];
                count_next = count_reg + 1'b1;
                walk_next  = '0;
                state_next = cur_reg.last ? ST_GRP_RD : ST_IDLE;
            end
            ST_GRP_RD:
            begin
                state_next = ST_GRP_CHK;
            end
            ST_GRP_CHK:
            begin
                rank_we = 1'b1;
                if (walk_reg == '0 || gap >= (PROJ_W+1)'(gap_limit))
                begin
                    base_next = $signed(srt_p_q);
                    rank_next = '0;
                end
                else
                    rank_next = rank_reg + 1'b1;
                if (walk_inc == count_reg)
                begin
                    walk_next  = '0;
                    state_next = ST_EM_RD;
                end
                else
                begin
                    walk_next  = walk_inc;
                    state_next = ST_GRP_RD;
                end
            end
            ST_EM_RD:
            begin
                state_next = ST_EM_M1;
            end
            ST_EM_M1:
            begin
                state_next = ST_EM_M2;
            end
            ST_EM_M2:
            begin
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT:
            begin
                if (out_load)
                begin
                    if (walk_inc == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        walk_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        walk_next  = walk_inc;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            walk_reg      <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            walk_reg  <= walk_next;
            rank_reg  <= rank_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        base_reg <= base_next;
        d_reg    <= rank_q * nudge_step;
        dx_reg   <= $signed({1'b0, d_reg}) * axis_cos;
        dy_reg   <= $signed({1'b0, d_reg}) * axis_sin;
        if (out_load)
        begin
            idx_out_reg  <= OUT_IDX_W'(walk_reg);
            nx_out_reg   <= sat_x;
            ny_out_reg   <= sat_y;
            last_out_reg <= (walk_inc == count_reg);
            ovf_out_reg  <= ovf_reg;
        end
    end

    // vertex and rank memories
    always_ff @(posedge clk)
    begin
        if (xy_we)
        begin
            x_mem[count_reg[IW-1:0]] <= q_data.x;
            y_mem[count_reg[IW-1:0]] <= q_data.y;
        end
        if (rank_we)
            rank_mem[srt_i_q] <= rank_next;
        x_q    <= x_mem[walk_reg[IW-1:0]];
        y_q    <= y_mem[walk_reg[IW-1:0]];
        rank_q <= rank_mem[walk_reg[IW-1:0]];
    end

    // sorted list memory
    always_ff @(posedge clk)
    begin
        if (srt_we)
        begin
            srt_p_mem[srt_waddr] <= srt_wp;
            srt_i_mem[srt_waddr] <= srt_wi;
        end
        srt_p_q <= srt_p_mem[srt_raddr];
        srt_i_q <= srt_i_mem[srt_raddr];
    end

    assign out_valid    = out_valid_reg;
    assign load_index   = idx_out_reg;
    assign new_x        = nx_out_reg;
    assign new_y        = ny_out_reg;
    assign last_out     = last_out_reg;
    assign overflow     = ovf_out_reg;

endmodule
